/* rtl/compass_calibration_point_finder_defines.svh */
// ----------------------------------------------------------------------------
// Compass calibration point finder: assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COMPASS_CALIBRATION_POINT_FINDER_DEFINES_SVH
`define COMPASS_CALIBRATION_POINT_FINDER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define CPF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/cpf_pkg.sv */
// ----------------------------------------------------------------------------
// Compass calibration point finder: shared package
// Types, widths, register indexes, status codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package cpf_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int MAG_W   = 16;
    localparam int POINT_W = 24;
    localparam int DIST_W  = 50;
    localparam int CHUNK_W = 25;
    localparam int OPND_W  = 26;
    localparam int ACC_W   = 64;
    localparam int RSUM_W  = 27;
    localparam int CNT_W   = 10;

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_AVG_COUNT     = 3'd0;
    localparam logic [2:0] REG_NOISE_COUNT   = 3'd1;
    localparam logic [2:0] REG_MARK_FACTOR   = 3'd2;
    localparam logic [2:0] REG_RETURN_FACTOR = 3'd3;
    localparam logic [2:0] REG_SPAN_FACTOR   = 3'd4;
    localparam logic [2:0] REG_S_MARGIN_DIV  = 3'd5;

    // Status codes, also the phase of the calibration.
    localparam logic [2:0] PH_AVG    = 3'd0;
    localparam logic [2:0] PH_NOISE  = 3'd1;
    localparam logic [2:0] PH_TRACK  = 3'd2;
    localparam logic [2:0] PH_DONE   = 3'd3;
    localparam logic [2:0] PH_ERR    = 3'd4;
    localparam logic [2:0] PH_NOMARK = 3'd5;

    localparam logic [9:0]  RST_AVG_COUNT     = 10'd100;
    localparam logic [9:0]  RST_NOISE_COUNT   = 10'd100;
    localparam logic [7:0]  RST_MARK_FACTOR   = 8'd80;
    localparam logic [7:0]  RST_RETURN_FACTOR = 8'd2;
    localparam logic [11:0] RST_SPAN_FACTOR   = 12'd1000;
    localparam logic [7:0]  RST_S_MARGIN_DIV  = 8'd10;

    typedef struct packed {
        logic [9:0]  avg_count;
        logic [9:0]  noise_count;
        logic [7:0]  mark_factor;
        logic [7:0]  return_factor;
        logic [11:0] span_factor;
        logic [7:0]  s_margin_divisor;
    } cfg_t;

    typedef struct packed {
        logic               issue;
        logic               clear;
        logic               shift;
        logic signed [25:0] a;
        logic signed [25:0] b;
    } mac_cmd_t;

endpackage

`default_nettype wire

/* rtl/cpf_regs.sv */
// ----------------------------------------------------------------------------
// Compass calibration point finder: configuration registers
// APB-style register file holding the six calibration settings.
// ----------------------------------------------------------------------------
`default_nettype none

module cpf_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpf_pkg::PADDR_W-1:0]  paddr,
    input  logic [cpf_pkg::PDATA_W-1:0]  pwdata,
    output logic [cpf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output cpf_pkg::cfg_t                cfg
);
    import cpf_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx    = paddr[PADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_AVG_COUNT:     cfg_next.avg_count        = pwdata[9:0];
                REG_NOISE_COUNT:   cfg_next.noise_count      = pwdata[9:0];
                REG_MARK_FACTOR:   cfg_next.mark_factor      = pwdata[7:0];
                REG_RETURN_FACTOR: cfg_next.return_factor    = pwdata[7:0];
                REG_SPAN_FACTOR:   cfg_next.span_factor      = pwdata[11:0];
                REG_S_MARGIN_DIV:  cfg_next.s_margin_divisor = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_AVG_COUNT:     prdata = {22'd0, cfg_reg.avg_count};
            REG_NOISE_COUNT:   prdata = {22'd0, cfg_reg.noise_count};
            REG_MARK_FACTOR:   prdata = {24'd0, cfg_reg.mark_factor};
            REG_RETURN_FACTOR: prdata = {24'd0, cfg_reg.return_factor};
            REG_SPAN_FACTOR:   prdata = {20'd0, cfg_reg.span_factor};
            REG_S_MARGIN_DIV:  prdata = {24'd0, cfg_reg.s_margin_divisor};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.avg_count        <= RST_AVG_COUNT;
            cfg_reg.noise_count      <= RST_NOISE_COUNT;
            cfg_reg.mark_factor      <= RST_MARK_FACTOR;
            cfg_reg.return_factor    <= RST_RETURN_FACTOR;
            cfg_reg.span_factor      <= RST_SPAN_FACTOR;
            cfg_reg.s_margin_divisor <= RST_S_MARGIN_DIV;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/cpf_mac.sv */
// ----------------------------------------------------------------------------
// Compass calibration point finder: shared multiply-accumulate unit
// One 26 by 26 signed multiplier, a product register and a 64-bit accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module cpf_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  cpf_pkg::mac_cmd_t                 cmd,
    output logic signed [cpf_pkg::ACC_W-1:0]  acc
);
    import cpf_pkg::*;

    logic signed [2*OPND_W-1:0] prod_reg;
    logic                       pv_reg;
    logic                       pclr_reg;
    logic                       pshift_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    base;

    assign acc      = acc_reg;
    assign prod_ext = ACC_W'(prod_reg);

    always_comb
    begin
        base     = pclr_reg ? '0 : acc_reg;
        acc_next = acc_reg;
        if (pv_reg)
        begin
            // The high chunk of a wide operand lands 25 bits up.
            acc_next = base + (pshift_reg ? (prod_ext <<< CHUNK_W) : prod_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= 1'b0;
        end
        else
        begin
            pv_reg <= cmd.issue;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= cmd.a * cmd.b;
        pclr_reg   <= cmd.clear;
        pshift_reg <= cmd.shift;
        acc_reg    <= acc_next;
    end

endmodule

`default_nettype wire

/* rtl/cpf_div.sv */
// ----------------------------------------------------------------------------
// Compass calibration point finder: bit-serial divider
// Restoring division, one quotient bit per cycle, rounded towards minus infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module cpf_div #(
    parameter int DVW = 48,
    parameter int DSW = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                neg,
    input  logic [DVW-1:0]                      dividend,
    input  logic [DSW-1:0]                      divisor,
    output logic                                done,
    output logic signed [cpf_pkg::POINT_W-1:0]  quot
);
    import cpf_pkg::*;

    localparam int CW = $clog2(DVW + 1);

    logic [DVW-1:0] quo_reg;
    logic [DSW-1:0] rem_reg;
    logic [DSW-1:0] dsr_reg;
    logic           neg_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [DSW:0]   trial;
    logic           fits;
    logic [POINT_W-1:0] q_low;

    assign trial = {rem_reg, quo_reg[DVW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};
    assign done  = done_reg;
    assign q_low = quo_reg[POINT_W-1:0];

    // Floor for a negative dividend: -q, less one when a remainder is left.
    assign quot = neg_reg ? ((rem_reg != '0) ? ~q_low : -q_low) : q_low;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DVW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
            neg_reg <= neg;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DVW-2:0], fits};
            rem_reg <= fits ? DSW'(trial - {1'b0, dsr_reg}) : trial[DSW-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/compass_calibration_point_finder.sv */
// ----------------------------------------------------------------------------
// Compass calibration point finder
// Finds the north, west and centre points of a magnetometer calibration run.
// ----------------------------------------------------------------------------
// Usage: each transfer on the input channel (in_valid, in_stall) carries one
// magnetometer reading and a read-failure flag; each one produces exactly one
// transfer on the output channel (out_valid, out_stall) carrying the status
// and the current north, west and centre points. The six settings are to be
// written through the APB-style port while the block is idle; the block
// itself does not enforce this. A noise or tracking reading runs a sequence
// of products on the one shared multiplier (nine squares and eight partial
// products for a tracking reading). The reading that closes averaging or
// tracking also runs three divisions on the bit-serial divider, one after
// the other, each over a DVW-bit dividend (DVW is 48 by default). Readings
// in the final states run no products or divisions. The next reading is
// accepted once the block is idle again. Reset puts the block in the
// averaging phase with the north, west and centre points at zero and the
// settings at their defaults. When the receiver stalls, the result waits in
// the output register; the block still accepts and works on one further
// reading, and then holds it until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compass_calibration_point_finder_defines.svh"

module compass_calibration_point_finder #(
    parameter int MAX_MARKS_LOG2 = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpf_pkg::PADDR_W-1:0]  paddr,
    input  logic [cpf_pkg::PDATA_W-1:0]  pwdata,
    output logic [cpf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [15:0]           mag_x,
    input  logic signed [15:0]           mag_y,
    input  logic signed [15:0]           mag_z,
    input  logic                         read_failed,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [2:0]                   status,
    output logic signed [23:0]           north_x,
    output logic signed [23:0]           north_y,
    output logic signed [23:0]           north_z,
    output logic signed [23:0]           west_x,
    output logic signed [23:0]           west_y,
    output logic signed [23:0]           west_z,
    output logic signed [23:0]           center_x,
    output logic signed [23:0]           center_y,
    output logic signed [23:0]           center_z
);
    import cpf_pkg::*;

    // Mark sum width: a 16-bit reading summed up to 2^MAX_MARKS_LOG2 - 1 times.
    localparam int MSW = MAG_W + MAX_MARKS_LOG2;
    // Divider widths: the larger of the north and centre cases.
    localparam int DVW = (MSW + 8 > RSUM_W + 8) ? MSW + 8 : RSUM_W + 8;
    localparam int DSW = (MAX_MARKS_LOG2 > CNT_W) ? MAX_MARKS_LOG2 : CNT_W;

    // Step numbers of the tracking sequence on the shared multiplier.
    localparam logic [4:0] STEP_SQ_LAST    = 5'd8;
    localparam logic [4:0] STEP_NOISE_LAST = 5'd2;
    localparam logic [4:0] STEP_PROD_LAST  = 5'd16;
    localparam logic [4:0] STEP_CAP_DM     = 5'd4;
    localparam logic [4:0] STEP_CAP_DN     = 5'd7;
    localparam logic [4:0] STEP_CAP_DS     = 5'd10;
    localparam logic [4:0] STEP_CAP_NM     = 5'd12;
    localparam logic [4:0] STEP_CAP_NR     = 5'd14;
    localparam logic [4:0] STEP_CAP_NSP    = 5'd16;
    localparam logic [4:0] STEP_CAP_PD     = 5'd18;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_START    = 8'b0000_0010,
        ST_SEQ      = 8'b0000_0100,
        ST_DECIDE   = 8'b0000_1000,
        ST_CLOSE    = 8'b0001_0000,
        ST_DIV_GO   = 8'b0010_0000,
        ST_DIV_WAIT = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } state_t;

    cfg_t     cfg;
    mac_cmd_t mac_cmd;
    logic signed [ACC_W-1:0] acc;

    state_t state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [4:0] step_reg, step_next;
    logic [CNT_W-1:0] samp_reg, samp_next;
    logic signed [RSUM_W-1:0] rsum_reg [3];
    logic signed [RSUM_W-1:0] rsum_next [3];
    logic signed [POINT_W-1:0] north_reg [3];
    logic signed [POINT_W-1:0] north_next [3];
    logic signed [POINT_W-1:0] south_reg [3];
    logic signed [POINT_W-1:0] south_next [3];
    logic signed [POINT_W-1:0] last_reg [3];
    logic signed [POINT_W-1:0] last_next [3];
    logic signed [POINT_W-1:0] west_reg [3];
    logic signed [POINT_W-1:0] west_next [3];
    logic signed [POINT_W-1:0] center_reg [3];
    logic signed [POINT_W-1:0] center_next [3];
    logic signed [MSW-1:0] msum_reg [3];
    logic signed [MSW-1:0] msum_next [3];
    logic [MAX_MARKS_LOG2-1:0] mcount_reg, mcount_next;
    logic [DIST_W-1:0] noise_reg, noise_next;
    logic [DIST_W-1:0] span_reg, span_next;
    logic [DIST_W-1:0] best_reg, best_next;
    logic signed [MAG_W-1:0] mag_reg [3];
    logic signed [MAG_W-1:0] mag_next [3];
    logic fail_reg, fail_next;
    logic [DIST_W-1:0] dm_reg, dm_next, dn_reg, dn_next, ds_reg, ds_next;
    logic [57:0] nm_reg, nm_next, nr_reg, nr_next, pd_reg, pd_next;
    logic [61:0] nsp_reg, nsp_next;
    logic end_reg, end_next;
    logic [1:0] axis_reg, axis_next;
    logic ctr_mode_reg, ctr_mode_next;

    logic out_valid_reg, out_valid_next;
    logic out_load;
    logic [2:0] st_out_reg;
    logic signed [POINT_W-1:0] n_out_reg [3];
    logic signed [POINT_W-1:0] w_out_reg [3];
    logic signed [POINT_W-1:0] c_out_reg [3];

    // Operand selection.
    logic [1:0] sq_axis;
    logic signed [POINT_W-1:0] sq_point;
    logic signed [POINT_W:0] sq_diff;
    logic [DIST_W-1:0] fac_src;
    logic [11:0] fac;
    logic [CHUNK_W-1:0] chunk;
    logic [DIST_W-1:0] dn_m_span;
    logic [7:0] div_eff;
    logic [CNT_W-1:0] avg_eff, noise_eff;

    // Divider interface.
    logic div_start, div_done, div_neg;
    logic [DVW-1:0] div_dvd;
    logic [DSW-1:0] div_dsr;
    logic signed [POINT_W-1:0] div_quot;
    logic [RSUM_W-1:0] rsum_abs;
    logic [MSW-1:0] msum_abs;

    // Decision terms.
    logic mark_hit, s_new, at_limit;
    logic [DIST_W-1:0] ds_eff, bd_eff, span_eff, diff;
    logic [CNT_W-1:0] samp_inc;

    cpf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mac_cmd),
        .acc   (acc)
    );

    cpf_div #(
        .DVW (DVW),
        .DSW (DSW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .neg      (div_neg),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quot     (div_quot)
    );

    // Zero counts and a zero divisor behave as one.
    assign div_eff   = (cfg.s_margin_divisor == 8'd0) ? 8'd1 : cfg.s_margin_divisor;
    assign avg_eff   = (cfg.avg_count == '0) ? CNT_W'(1) : cfg.avg_count;
    assign noise_eff = (cfg.noise_count == '0) ? CNT_W'(1) : cfg.noise_count;
    assign dn_m_span = dn_reg - span_reg;
    assign samp_inc  = samp_reg + CNT_W'(1);

    // The multiplier schedule: squares of the distances to the last mark,
    // north and south first, then the noise products split in two 25-bit
    // halves, and last the span gain times the margin divisor.
    always_comb
    begin
        unique case (step_reg)
            5'd0, 5'd3, 5'd6: sq_axis = 2'd0;
            5'd1, 5'd4, 5'd7: sq_axis = 2'd1;
            5'd2, 5'd5, 5'd8: sq_axis = 2'd2;
            default:          sq_axis = 2'd0;
        endcase

        if (step_reg < 5'd3)
        begin
            sq_point = (phase_reg == PH_NOISE) ? north_reg[sq_axis] : last_reg[sq_axis];
        end
        else if (step_reg < 5'd6)
        begin
            sq_point = north_reg[sq_axis];
        end
        else
        begin
            sq_point = south_reg[sq_axis];
        end
        sq_diff = {sq_point[POINT_W-1], sq_point}
                - {mag_reg[sq_axis][MAG_W-1], mag_reg[sq_axis], 8'h00};

        unique case (step_reg)
            5'd9, 5'd10:
            begin
                fac_src = noise_reg;
                fac     = {4'd0, cfg.mark_factor};
            end
            5'd11, 5'd12:
            begin
                fac_src = noise_reg;
                fac     = {4'd0, cfg.return_factor};
            end
            5'd13, 5'd14:
            begin
                fac_src = noise_reg;
                fac     = cfg.span_factor;
            end
            5'd15, 5'd16:
            begin
                fac_src = dn_m_span;
                fac     = {4'd0, div_eff};
            end
            default:
            begin
                fac_src = noise_reg;
                fac     = '0;
            end
        endcase
        // Odd steps carry the low half, even steps the high half.
        chunk = step_reg[0] ? fac_src[CHUNK_W-1:0] : fac_src[DIST_W-1:CHUNK_W];

        mac_cmd.issue = (state_reg == ST_SEQ) &&
                        ((phase_reg == PH_NOISE) ? (step_reg <= STEP_NOISE_LAST)
                                                 : (step_reg <= STEP_PROD_LAST));
        mac_cmd.clear = (step_reg == 5'd0) || (step_reg == 5'd3) || (step_reg == 5'd6) ||
                        (step_reg == 5'd9) || (step_reg == 5'd11) ||
                        (step_reg == 5'd13) || (step_reg == 5'd15);
        mac_cmd.shift = (step_reg > STEP_SQ_LAST) && !step_reg[0];
        if (step_reg <= STEP_SQ_LAST)
        begin
            mac_cmd.a = {sq_diff[POINT_W], sq_diff};
            mac_cmd.b = {sq_diff[POINT_W], sq_diff};
        end
        else
        begin
            mac_cmd.a = {1'b0, chunk};
            mac_cmd.b = {14'd0, fac};
        end
    end

    // Divider operands: magnitude of the sum times 256, and its sign.
    always_comb
    begin
        rsum_abs = rsum_reg[axis_reg][RSUM_W-1] ? RSUM_W'(-rsum_reg[axis_reg])
                                                : RSUM_W'(rsum_reg[axis_reg]);
        msum_abs = msum_reg[axis_reg][MSW-1] ? MSW'(-msum_reg[axis_reg])
                                             : MSW'(msum_reg[axis_reg]);
        if (ctr_mode_reg)
        begin
            div_neg = msum_reg[axis_reg][MSW-1];
            div_dvd = DVW'({msum_abs, 8'h00});
            div_dsr = DSW'(mcount_reg);
        end
        else
        begin
            div_neg = rsum_reg[axis_reg][RSUM_W-1];
            div_dvd = DVW'({rsum_abs, 8'h00});
            div_dsr = DSW'(samp_reg);
        end
    end

    // Decision terms of a tracking reading, from the captured distances and the mark count.
    always_comb
    begin
        mark_hit = {8'd0, dm_reg} > nm_reg;
        at_limit = (mcount_reg == {MAX_MARKS_LOG2{1'b1}});
        s_new    = (dn_reg > span_reg) && (pd_reg > {8'd0, ds_reg});
        ds_eff   = s_new ? '0 : ds_reg;
        bd_eff   = s_new ? dn_reg : best_reg;
        span_eff = s_new ? dn_reg : span_reg;
        diff     = (dn_reg >= ds_eff) ? (dn_reg - ds_eff) : (ds_eff - dn_reg);
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        step_next     = step_reg;
        samp_next     = samp_reg;
        rsum_next     = rsum_reg;
        north_next    = north_reg;
        south_next    = south_reg;
        last_next     = last_reg;
        west_next     = west_reg;
        center_next   = center_reg;
        msum_next     = msum_reg;
        mcount_next   = mcount_reg;
        noise_next    = noise_reg;
        span_next     = span_reg;
        best_next     = best_reg;
        mag_next      = mag_reg;
        fail_next     = fail_reg;
        dm_next       = dm_reg;
        dn_next       = dn_reg;
        ds_next       = ds_reg;
        nm_next       = nm_reg;
        nr_next       = nr_reg;
        nsp_next      = nsp_reg;
        pd_next       = pd_reg;
        end_next      = end_reg;
        axis_next     = axis_reg;
        ctr_mode_next = ctr_mode_reg;
        div_start     = 1'b0;
        out_load      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mag_next[0] = mag_x;
                    mag_next[1] = mag_y;
                    mag_next[2] = mag_z;
                    fail_next   = read_failed;
                    state_next  = ST_START;
                end
            end

            ST_START:
            begin
                if ((phase_reg <= PH_TRACK) && fail_reg)
                begin
                    phase_next = PH_ERR;
                    state_next = ST_FINISH;
                end
                else if (phase_reg == PH_AVG)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        rsum_next[i] = rsum_reg[i] + RSUM_W'(mag_reg[i]);
                    end
                    samp_next = samp_inc;
                    if (samp_inc >= avg_eff)
                    begin
                        ctr_mode_next = 1'b0;
                        axis_next     = 2'd0;
                        state_next    = ST_DIV_GO;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if ((phase_reg == PH_NOISE) || (phase_reg == PH_TRACK))
                begin
                    step_next  = '0;
                    state_next = ST_SEQ;
                end
                else
                begin
                    // Final states repeat their result and ignore the reading.
                    state_next = ST_FINISH;
                end
            end

            ST_SEQ:
            begin
                step_next = step_reg + 5'd1;
                if (phase_reg == PH_NOISE)
                begin
                    if (step_reg == STEP_CAP_DM)
                    begin
                        if (acc[DIST_W-1:0] > noise_reg)
                        begin
                            noise_next = acc[DIST_W-1:0];
                        end
                        samp_next = samp_inc;
                        if (samp_inc >= noise_eff)
                        begin
                            samp_next = '0;
                            for (int i = 0; i < 3; i++)
                            begin
                                south_next[i]  = north_reg[i];
                                last_next[i]   = north_reg[i];
                                msum_next[i]   = '0;
                                center_next[i] = '0;
                            end
                            mcount_next = '0;
                            span_next   = '0;
                            best_next   = '0;
                            phase_next  = PH_TRACK;
                        end
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    if (step_reg == STEP_CAP_DM)
                    begin
                        dm_next = acc[DIST_W-1:0];
                    end
                    if (step_reg == STEP_CAP_DN)
                    begin
                        dn_next = acc[DIST_W-1:0];
                    end
                    if (step_reg == STEP_CAP_DS)
                    begin
                        ds_next = acc[DIST_W-1:0];
                    end
                    if (step_reg == STEP_CAP_NM)
                    begin
                        nm_next = acc[57:0];
                    end
                    if (step_reg == STEP_CAP_NR)
                    begin
                        nr_next = acc[57:0];
                    end
                    if (step_reg == STEP_CAP_NSP)
                    begin
                        nsp_next = acc[61:0];
                    end
                    if (step_reg == STEP_CAP_PD)
                    begin
                        pd_next    = acc[57:0];
                        state_next = ST_DECIDE;
                    end
                end
            end

            ST_DECIDE:
            begin
                if (mark_hit)
                begin
                    if (!at_limit)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            msum_next[i] = msum_reg[i] + MSW'(mag_reg[i]);
                        end
                        mcount_next = mcount_reg + 1'b1;
                    end
                    for (int i = 0; i < 3; i++)
                    begin
                        last_next[i] = {mag_reg[i], 8'h00};
                    end
                end
                if (s_new)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        south_next[i] = {mag_reg[i], 8'h00};
                    end
                    span_next = dn_reg;
                end
                best_next = bd_eff;
                if (diff < bd_eff)
                begin
                    best_next = diff;
                    for (int i = 0; i < 3; i++)
                    begin
                        west_next[i] = {mag_reg[i], 8'h00};
                    end
                end
                end_next   = ({8'd0, dn_reg} <= nr_reg) && ({12'd0, span_eff} >= nsp_reg);
                state_next = ST_CLOSE;
            end

            ST_CLOSE:
            begin
                if (end_reg)
                begin
                    if (mcount_reg == '0)
                    begin
                        phase_next = PH_NOMARK;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        ctr_mode_next = 1'b1;
                        axis_next     = 2'd0;
                        state_next    = ST_DIV_GO;
                    end
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (ctr_mode_reg)
                    begin
                        center_next[axis_reg] = div_quot;
                    end
                    else
                    begin
                        north_next[axis_reg] = div_quot;
                    end
                    if (axis_reg == 2'd2)
                    begin
                        if (ctr_mode_reg)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            samp_next  = '0;
                            noise_next = '0;
                            phase_next = PH_NOISE;
                        end
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load | (out_valid_reg & out_stall);
    assign in_stall       = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_AVG;
            step_reg      <= '0;
            samp_reg      <= '0;
            noise_reg     <= '0;
            span_reg      <= '0;
            best_reg      <= '0;
            mcount_reg    <= '0;
            out_valid_reg <= 1'b0;
            axis_reg      <= '0;
            ctr_mode_reg  <= 1'b0;
            end_reg       <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                rsum_reg[i]   <= '0;
                north_reg[i]  <= '0;
                west_reg[i]   <= '0;
                center_reg[i] <= '0;
                msum_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            samp_reg      <= samp_next;
            noise_reg     <= noise_next;
            span_reg      <= span_next;
            best_reg      <= best_next;
            mcount_reg    <= mcount_next;
            out_valid_reg <= out_valid_next;
            axis_reg      <= axis_next;
            ctr_mode_reg  <= ctr_mode_next;
            end_reg       <= end_next;
            rsum_reg      <= rsum_next;
            north_reg     <= north_next;
            west_reg      <= west_next;
            center_reg    <= center_next;
            msum_reg      <= msum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        south_reg <= south_next;
        last_reg  <= last_next;
        mag_reg   <= mag_next;
        fail_reg  <= fail_next;
        dm_reg    <= dm_next;
        dn_reg    <= dn_next;
        ds_reg    <= ds_next;
        nm_reg    <= nm_next;
        nr_reg    <= nr_next;
        nsp_reg   <= nsp_next;
        pd_reg    <= pd_next;
        if (out_load)
        begin
            st_out_reg <= phase_reg;
            for (int i = 0; i < 3; i++)
            begin
                n_out_reg[i] <= north_reg[i];
                w_out_reg[i] <= west_reg[i];
                c_out_reg[i] <= (phase_reg == PH_DONE) ? center_reg[i] : '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = st_out_reg;
    assign north_x   = n_out_reg[0];
    assign north_y   = n_out_reg[1];
    assign north_z   = n_out_reg[2];
    assign west_x    = w_out_reg[0];
    assign west_y    = w_out_reg[1];
    assign west_z    = w_out_reg[2];
    assign center_x  = c_out_reg[0];
    assign center_y  = c_out_reg[1];
    assign center_z  = c_out_reg[2];

    // A reading that is taken in makes the block busy in the next cycle.
    `CPF_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall, "accepted reading left block idle")

    // Done, read error and no-marks are final until reset.
    `CPF_ASSERT_NEXT(a_final_holds, phase_reg == PH_DONE || phase_reg == PH_ERR || phase_reg == PH_NOMARK, $stable(phase_reg), "final phase changed")

    // The divider only reports while the sequencer waits for it.
    `CPF_ASSERT_NOW(a_div_done_wait, div_done, state_reg == ST_DIV_WAIT, "divider result not awaited")

endmodule

`default_nettype wire

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Compass calibration point finder: testbench
// Drives one complete calibration run through averaging, noise measurement
// and tracking of a turning vehicle. Each output transfer is checked against
// a cycle-free predictor of the calibration state, with random idling on
// both channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import cpf_pkg::*;

    localparam longint unsigned MARK_LIMIT = (64'd1 << 24) - 1;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               fail;
    } reading_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [2:0][23:0] north;
        logic [2:0][23:0] west;
        logic [2:0][23:0] center;
    } calib_result_t;

    // Clock, reset and block ports; every input starts at a known value.
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic signed [15:0]  mag_x = '0;
    logic signed [15:0]  mag_y = '0;
    logic signed [15:0]  mag_z = '0;
    logic                read_failed = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [2:0]          status;
    logic signed [23:0]  north_x, north_y, north_z;
    logic signed [23:0]  west_x, west_y, west_z;
    logic signed [23:0]  center_x, center_y, center_z;

    compass_calibration_point_finder i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mag_x      (mag_x),
        .mag_y      (mag_y),
        .mag_z      (mag_z),
        .read_failed(read_failed),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .north_x    (north_x),
        .north_y    (north_y),
        .north_z    (north_z),
        .west_x     (west_x),
        .west_y     (west_y),
        .west_z     (west_z),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Readings waiting to be offered, and results waiting to be seen.
    reading_t      readings_q[$];
    calib_result_t expected_q[$];
    int            error_count = 0;
    int            tx_idle_pct = 0;
    int            rx_stall_pct = 0;
    logic          hold_req = 1'b0;
    logic          hold_done = 1'b0;
    int            hold_left = 0;

    // Predictor state: a private copy of the settings and of the calibration.
    cfg_t              cfg;
    logic [2:0]        phase;
    longint unsigned   samples;
    longint            reading_sum[3];
    longint            north_pt[3];
    longint            south_pt[3];
    longint            mark_pt[3];
    longint            west_pt[3];
    longint            mark_sum[3];
    longint            center_pt[3];
    longint unsigned   noise_level;
    longint unsigned   span_ns;
    longint unsigned   best_diff;
    longint unsigned   mark_count;

    initial
    begin
        cfg = '{RST_AVG_COUNT, RST_NOISE_COUNT, RST_MARK_FACTOR,
                RST_RETURN_FACTOR, RST_SPAN_FACTOR, RST_S_MARGIN_DIV};
        phase = PH_AVG;
        samples = 0;
        noise_level = 0;
        span_ns = 0;
        best_diff = 0;
        mark_count = 0;
        for (int i = 0; i < 3; i++)
        begin
            reading_sum[i] = 0; north_pt[i] = 0; south_pt[i] = 0;
            mark_pt[i] = 0; west_pt[i] = 0; mark_sum[i] = 0; center_pt[i] = 0;
        end
    end

    function automatic longint floor_quot(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // Squared distance of two Q8 points; exact and below 2^50.
    function automatic longint unsigned dist2(input longint a[3], input longint b[3]);
        longint unsigned s;
        longint d;
        s = 0;
        for (int i = 0; i < 3; i++)
        begin
            d = a[i] - b[i];
            s += longint'(d * d);
        end
        return s;
    endfunction

    // Advances the calibration by one accepted reading and queues its result.
    task automatic advance_calibration(input reading_t rd);
        longint          r[3];
        longint unsigned dn, ds, dm, diff, div, cnt;
        calib_result_t   res;
        r[0] = longint'(rd.x) * 256;
        r[1] = longint'(rd.y) * 256;
        r[2] = longint'(rd.z) * 256;
        if (phase <= PH_TRACK && rd.fail)
            phase = PH_ERR;
        else if (phase == PH_AVG)
        begin
            for (int i = 0; i < 3; i++)
                reading_sum[i] += longint'(rd.x) * 0 + (r[i] >>> 8);
            samples++;
            cnt = (cfg.avg_count == 0) ? 1 : cfg.avg_count;
            if (samples >= cnt)
            begin
                for (int i = 0; i < 3; i++)
                    north_pt[i] = floor_quot(reading_sum[i] * 256, longint'(samples));
                samples = 0;
                noise_level = 0;
                phase = PH_NOISE;
            end
        end
        else if (phase == PH_NOISE)
        begin
            dn = dist2(r, north_pt);
            if (dn > noise_level)
                noise_level = dn;
            samples++;
            cnt = (cfg.noise_count == 0) ? 1 : cfg.noise_count;
            if (samples >= cnt)
            begin
                samples = 0;
                for (int i = 0; i < 3; i++)
                begin
                    south_pt[i] = north_pt[i];
                    mark_pt[i] = north_pt[i];
                    mark_sum[i] = 0;
                    center_pt[i] = 0;
                end
                mark_count = 0;
                span_ns = 0;
                best_diff = 0;
                phase = PH_TRACK;
            end
        end
        else if (phase == PH_TRACK)
        begin
            dn = dist2(r, north_pt);
            ds = dist2(r, south_pt);
            dm = dist2(r, mark_pt);
            // A reading far enough from the last mark becomes a new mark.
            if (dm > noise_level * cfg.mark_factor)
            begin
                if (mark_count < MARK_LIMIT)
                begin
                    for (int i = 0; i < 3; i++)
                        mark_sum[i] += r[i] >>> 8;
                    mark_count++;
                end
                for (int i = 0; i < 3; i++)
                    mark_pt[i] = r[i];
            end
            div = (cfg.s_margin_divisor == 0) ? 1 : cfg.s_margin_divisor;
            if (dn > span_ns && (dn - span_ns) * div > ds)
            begin
                for (int i = 0; i < 3; i++)
                    south_pt[i] = r[i];
                span_ns = dn;
                best_diff = dn;
                ds = 0;
            end
            diff = (dn > ds) ? dn - ds : ds - dn;
            if (diff < best_diff)
            begin
                best_diff = diff;
                for (int i = 0; i < 3; i++)
                    west_pt[i] = r[i];
            end
            if (dn <= noise_level * cfg.return_factor &&
                span_ns >= noise_level * cfg.span_factor)
            begin
                if (mark_count == 0)
                    phase = PH_NOMARK;
                else
                begin
                    for (int i = 0; i < 3; i++)
                        center_pt[i] = floor_quot(mark_sum[i] * 256, longint'(mark_count));
                    phase = PH_DONE;
                end
            end
        end
        res.status = phase;
        for (int i = 0; i < 3; i++)
        begin
            res.north[i] = north_pt[i][23:0];
            res.west[i] = west_pt[i][23:0];
            res.center[i] = (phase == PH_DONE) ? center_pt[i][23:0] : 24'd0;
        end
        expected_q.push_back(res);
    endtask

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
        error_count++;
    endtask

    // Driver: offers the next reading once the previous transfer is done.
    always @(posedge clk)
    begin
        reading_t rd;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                rd.x = mag_x; rd.y = mag_y; rd.z = mag_z; rd.fail = read_failed;
                advance_calibration(rd);
            end
            if (!in_valid || !in_stall)
            begin
                if (readings_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    rd = readings_q.pop_front();
                    in_valid <= 1'b1;
                    mag_x <= rd.x;
                    mag_y <= rd.y;
                    mag_z <= rd.z;
                    read_failed <= rd.fail;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver stall, with a single long hold-off on request so that the
    // output register fills and the block stalls its input.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else if (hold_req && !hold_done)
            begin
                hold_left <= 400;
                hold_done <= 1'b1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Monitor: every output transfer is compared with the oldest expectation.
    always @(posedge clk)
    begin
        calib_result_t got;
        calib_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status = status;
            got.north = {north_z, north_y, north_x};
            got.west = {west_z, west_y, west_x};
            got.center = {center_z, center_y, center_x};
            if (expected_q.size() == 0)
            begin
                $display("%0t: output transfer with no result expected", $realtime);
                error_count++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
                for (int i = 0; i < 3; i++)
                begin
                    if (got.north[i] != want.north[i])
                        report_mismatch($sformatf("north[%0d]", i),
                                        signed'(got.north[i]), signed'(want.north[i]));
                    if (got.west[i] != want.west[i])
                        report_mismatch($sformatf("west[%0d]", i),
                                        signed'(got.west[i]), signed'(want.west[i]));
                    if (got.center[i] != want.center[i])
                        report_mismatch($sformatf("center[%0d]", i),
                                        signed'(got.center[i]), signed'(want.center[i]));
                end
            end
        end
    end

    task automatic push_reading(input int x, input int y, input int z, input logic fail);
        reading_t rd;
        rd.x = x; rd.y = y; rd.z = z; rd.fail = fail;
        readings_q.push_back(rd);
    endtask

    // Waits until every reading has been accepted and every result seen,
    // then lets the dividers of a closing reading run out.
    task automatic wait_idle();
        while (readings_q.size() != 0 || in_valid || expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_AVG_COUNT:     cfg.avg_count = value[9:0];
            REG_NOISE_COUNT:   cfg.noise_count = value[9:0];
            REG_MARK_FACTOR:   cfg.mark_factor = value[7:0];
            REG_RETURN_FACTOR: cfg.return_factor = value[7:0];
            REG_SPAN_FACTOR:   cfg.span_factor = value[11:0];
            REG_S_MARGIN_DIV:  cfg.s_margin_divisor = value[7:0];
            default: ;
        endcase
    endtask

    // Stimulus. The vehicle faces north at P, the noise run stays within two
    // counts of P, and then the vehicle turns a circle of radius R through P.
    localparam int PX = 1000, PY = -500, PZ = 300, RADIUS = 2000;
    localparam int TURN_STEPS = 320;

    initial
    begin
        int    fail_at;
        real   ang;
        int    jx, jy, jz;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Averaging with the largest counts, then cut short: the phase ends
        // as soon as the count has passed the smaller setting.
        write_reg(REG_AVG_COUNT, 1023);
        write_reg(REG_NOISE_COUNT, 1023);
        write_reg(REG_MARK_FACTOR, 255);
        write_reg(REG_RETURN_FACTOR, 2);
        write_reg(REG_SPAN_FACTOR, 4095);
        write_reg(REG_S_MARGIN_DIV, 0);
        push_reading(PX, PY, PZ, 1'b0);
        push_reading(PX + 1, PY + 1, PZ + 1, 1'b0);
        push_reading(PX - 1, PY - 1, PZ - 1, 1'b0);
        wait_idle();
        write_reg(REG_AVG_COUNT, 1);
        push_reading(PX, PY, PZ, 1'b0);

        // Noise run; a zero count acts as one and closes the phase.
        push_reading(PX + 2, PY + 2, PZ + 2, 1'b0);
        push_reading(PX - 1, PY, PZ - 1, 1'b0);
        push_reading(PX, PY, PZ, 1'b0);
        wait_idle();
        write_reg(REG_NOISE_COUNT, 0);
        push_reading(PX, PY + 1, PZ, 1'b0);
        wait_idle();

        // Tracking starts with the extremes of every axis.
        write_reg(REG_MARK_FACTOR, 0);
        write_reg(REG_SPAN_FACTOR, 1000);
        write_reg(REG_S_MARGIN_DIV, 255);
        push_reading(32767, 32767, 32767, 1'b0);
        push_reading(-32768, -32768, -32768, 1'b0);
        push_reading(32767, -32768, 0, 1'b0);
        push_reading(-32768, 32767, -1, 1'b0);
        push_reading(0, 0, 0, 1'b0);
        wait_idle();
        write_reg(REG_MARK_FACTOR, 80);
        write_reg(REG_S_MARGIN_DIV, 1);

        // The turn. Now and then a wild reading; in some runs a failed read
        // ends the calibration part way round.
        fail_at = ($urandom_range(3) == 0) ? $urandom_range(TURN_STEPS - 1, 20) : -1;
        for (int k = 0; k < TURN_STEPS; k++)
        begin
            if (k % 80 == 0)
            begin
                case (k / 80)
                    0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                    1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
                    2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
                    default: begin tx_idle_pct = 34; rx_stall_pct = 34; end
                endcase
            end
            if (k == 120)
            begin
                // Settings changed part way round, between transfers.
                wait_idle();
                write_reg(REG_RETURN_FACTOR, 255);
                write_reg(REG_SPAN_FACTOR, 0);
                write_reg(REG_S_MARGIN_DIV, 10);
            end
            if (k == 200)
            begin
                wait_idle();
                write_reg(REG_RETURN_FACTOR, 0);
                write_reg(REG_MARK_FACTOR, 255);
                hold_req <= 1'b1;
            end
            ang = 6.283185307 * (k + 1) / (TURN_STEPS + 2);
            jx = $urandom_range(40) - 20;
            jy = $urandom_range(40) - 20;
            jz = $urandom_range(100) - 50;
            if ($urandom_range(9) == 0)
                push_reading($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                             $urandom_range(65535) - 32768, k == fail_at);
            else
                push_reading(PX - RADIUS + $rtoi(RADIUS * $cos(ang)) + jx,
                             PY + $rtoi(RADIUS * $sin(ang)) + jy, PZ + jz, k == fail_at);
        end
        wait_idle();
        write_reg(REG_RETURN_FACTOR, 2);
        write_reg(REG_SPAN_FACTOR, 4095);
        write_reg(REG_MARK_FACTOR, 80);

        // Back at north: the calibration closes, and from here every reading
        // is ignored, a failed read too.
        push_reading(PX, PY, PZ, 1'b0);
        push_reading(32767, -32768, 32767, 1'b1);
        push_reading(-32768, 32767, -32768, 1'b0);
        for (int k = 0; k < 220; k++)
        begin
            if (k % 60 == 0)
            begin
                tx_idle_pct = (k / 60) % 2 ? 80 : 0;
                rx_stall_pct = (k / 120) % 2 ? 80 : 34;
            end
            push_reading($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                         $urandom_range(65535) - 32768, $urandom_range(1));
        end
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
